@@ rtl/vgrm_pkg.sv @@
`default_nettype none

package vgrm_pkg;

  // input word kinds, carried on in_tuser
  localparam logic [1:0] ACT_SET   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_CAST  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DEPTH  = 2'd2;

  localparam int POS_W  = 18;  // signed Q10.8 march point (Q8.8 with headroom)
  localparam int STEP_W = 10;  // signed Q2.8 step
  localparam int ORG_W  = 16;  // signed Q8.8 origin
  localparam int EXT_W  = 5;   // in-use size

  typedef logic signed [POS_W-1:0] pos_t;

  // clamp an in-use size to 1..lim
  function automatic logic [EXT_W-1:0] eff_ext(logic [EXT_W-1:0] r, logic [EXT_W-1:0] lim);
    logic [EXT_W-1:0] v;
    v = r;
    if (v == '0) v = EXT_W'(1);
    if (v > lim) v = lim;
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/voxel_grid_ray_march_top.sv @@
`default_nettype none

// Channel   Dir  Handshake            Payload
// in_       in   in_tvalid/in_tready  in_tuser: action; in_tdata: cell, origin, step
// out_      out  out_tvalid/out_tready out_tuser: hit_valid; out_tdata: hit cell; out_tlast
// cfg_      in   cfg_we (no stall)    cfg_index, cfg_wdata
//
// Set and clear words are written (if the cell is in the grid) as they are accepted; in_tready stays high.
// A cast: an accept, then per step a registered occupancy read (S_LOOK) and a test and
// advance (S_TEST), for at most max(in-use sizes) + 1 steps, then an end state (S_END).
// After reset a clearing pass zeroes all 2**AW cells of the occupancy RAM (4096 at the
// default grid), one cell per cycle, with in_tready low; cfg writes are taken.
// A stalled result holds in the output register; the march waits only when a second hit
// or the final word finds that register still full.

module voxel_grid_ray_march_top #(
  parameter int GRID_X = 16,
  parameter int GRID_Y = 16,
  parameter int GRID_Z = 16
) (
  input  wire         clk,
  input  wire         rst_n,

  input  wire         in_tvalid,
  output logic        in_tready,
  // [1:0] action
  input  wire  [1:0]  in_tuser,
  // [3:0] cell_x, [7:4] cell_y, [11:8] cell_z, [27:12] origin_x, [43:28] origin_y,
  // [59:44] origin_z, [69:60] step_x, [79:70] step_y, [89:80] step_z, [95:90] zero
  input  wire  [95:0] in_tdata,

  output logic        out_tvalid,
  input  wire         out_tready,
  // [0] hit_valid
  output logic        out_tuser,
  // [3:0] hit_x, [7:4] hit_y, [11:8] hit_z, [15:12] zero
  output logic [15:0] out_tdata,
  output logic        out_tlast,

  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [4:0]  cfg_wdata
);

  localparam int EW = vgrm_pkg::EXT_W;
  localparam int PW = vgrm_pkg::POS_W;

  // usable extent per axis: cell indexes are 4 bits
  localparam int LIM_X = (GRID_X < 16) ? GRID_X : 16;
  localparam int LIM_Y = (GRID_Y < 16) ? GRID_Y : 16;
  localparam int LIM_Z = (GRID_Z < 16) ? GRID_Z : 16;
  localparam int XB = (LIM_X > 1) ? $clog2(LIM_X) : 1;
  localparam int YB = (LIM_Y > 1) ? $clog2(LIM_Y) : 1;
  localparam int ZB = (LIM_Z > 1) ? $clog2(LIM_Z) : 1;
  localparam int AW = XB + YB + ZB;
  localparam int DEPTH = 1 << AW;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_LOOK = 3'd2;
  localparam logic [2:0] S_TEST = 3'd3;
  localparam logic [2:0] S_END  = 3'd4;

  // ---------------- configuration
  logic [EW-1:0] w_r, h_r, d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= EW'(16);
      h_r <= EW'(16);
      d_r <= EW'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        vgrm_pkg::REG_WIDTH:  w_r <= cfg_wdata;
        vgrm_pkg::REG_HEIGHT: h_r <= cfg_wdata;
        vgrm_pkg::REG_DEPTH:  d_r <= cfg_wdata;
        default: ;  // unused index
      endcase
    end
  end

  logic [EW-1:0] ext_x, ext_y, ext_z, maxit;
  assign ext_x = vgrm_pkg::eff_ext(w_r, EW'(LIM_X));
  assign ext_y = vgrm_pkg::eff_ext(h_r, EW'(LIM_Y));
  assign ext_z = vgrm_pkg::eff_ext(d_r, EW'(LIM_Z));

  always_comb begin
    maxit = ext_x;
    if (ext_y > maxit) maxit = ext_y;
    if (ext_z > maxit) maxit = ext_z;
  end

  // bound in Q10.8 (pos_t), as a non-negative signed value
  vgrm_pkg::pos_t lim_x, lim_y, lim_z;
  assign lim_x = {5'd0, ext_x, 8'd0};
  assign lim_y = {5'd0, ext_y, 8'd0};
  assign lim_z = {5'd0, ext_z, 8'd0};

  // ---------------- input unpack
  logic [3:0] in_cx, in_cy, in_cz;
  logic [15:0] in_ox, in_oy, in_oz;
  logic [9:0] in_sx, in_sy, in_sz;
  assign in_cx = in_tdata[3:0];
  assign in_cy = in_tdata[7:4];
  assign in_cz = in_tdata[11:8];
  assign in_ox = in_tdata[27:12];
  assign in_oy = in_tdata[43:28];
  assign in_oz = in_tdata[59:44];
  assign in_sx = in_tdata[69:60];
  assign in_sy = in_tdata[79:70];
  assign in_sz = in_tdata[89:80];

  // ---------------- state
  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  vgrm_pkg::pos_t pos_x_r, pos_y_r, pos_z_r, pos_x_nxt, pos_y_nxt, pos_z_nxt;
  vgrm_pkg::pos_t stp_x_r, stp_y_r, stp_z_r, stp_x_nxt, stp_y_nxt, stp_z_nxt;
  logic [EW-1:0] cnt_r, cnt_nxt;
  logic          cand_r, cand_nxt;
  logic [3:0]    cur_x_r, cur_y_r, cur_z_r, cur_x_nxt, cur_y_nxt, cur_z_nxt;
  logic          pend_r, pend_nxt;
  logic [3:0]    pnd_x_r, pnd_y_r, pnd_z_r, pnd_x_nxt, pnd_y_nxt, pnd_z_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [3:0]    out_x_r, out_y_r, out_z_r, out_x_nxt, out_y_nxt, out_z_nxt;
  logic          out_hit_r, out_hit_nxt, out_last_r, out_last_nxt;

  // memory port
  logic          mem_we, mem_wd, mem_re, mem_rd;
  logic [AW-1:0] mem_wa, mem_ra;

  logic in_acc, out_free, inb, nonneg, hit, cell_ok;
  logic [EW-1:0] cnt_inc;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign inb    = (pos_x_r < lim_x) && (pos_y_r < lim_y) && (pos_z_r < lim_z);
  assign nonneg = !pos_x_r[PW-1] && !pos_y_r[PW-1] && !pos_z_r[PW-1];
  assign hit    = cand_r && mem_rd;
  assign cnt_inc = cnt_r + EW'(1);
  assign cell_ok = ({28'd0, in_cx} < 32'(GRID_X)) && ({28'd0, in_cy} < 32'(GRID_Y))
                && ({28'd0, in_cz} < 32'(GRID_Z));

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    pos_x_nxt = pos_x_r; pos_y_nxt = pos_y_r; pos_z_nxt = pos_z_r;
    stp_x_nxt = stp_x_r; stp_y_nxt = stp_y_r; stp_z_nxt = stp_z_r;
    cnt_nxt   = cnt_r;
    cand_nxt  = cand_r;
    cur_x_nxt = cur_x_r; cur_y_nxt = cur_y_r; cur_z_nxt = cur_z_r;
    pend_nxt  = pend_r;
    pnd_x_nxt = pnd_x_r; pnd_y_nxt = pnd_y_r; pnd_z_nxt = pnd_z_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_x_nxt = out_x_r; out_y_nxt = out_y_r; out_z_nxt = out_z_r;
    out_hit_nxt = out_hit_r; out_last_nxt = out_last_r;
    mem_we = 1'b0;
    mem_wa = {in_cx[XB-1:0], in_cy[YB-1:0], in_cz[ZB-1:0]};
    mem_wd = 1'b0;
    mem_re = 1'b0;
    mem_ra = {pos_x_r[8 +: XB], pos_y_r[8 +: YB], pos_z_r[8 +: ZB]};

    unique case (state_r)
      S_CLR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == {AW{1'b1}}) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          case (in_tuser) inside
            vgrm_pkg::ACT_SET, vgrm_pkg::ACT_CLEAR: begin
              mem_we = cell_ok;
              mem_wd = (in_tuser == vgrm_pkg::ACT_SET);
            end
            vgrm_pkg::ACT_CAST: begin
              pos_x_nxt = PW'($signed(in_ox));
              pos_y_nxt = PW'($signed(in_oy));
              pos_z_nxt = PW'($signed(in_oz));
              stp_x_nxt = PW'($signed(in_sx));
              stp_y_nxt = PW'($signed(in_sy));
              stp_z_nxt = PW'($signed(in_sz));
              cnt_nxt   = '0;
              pend_nxt  = 1'b0;
              state_nxt = S_LOOK;
            end
            default: ;  // unused action
          endcase
        end
      end
      S_LOOK: begin
        // loop test, then read the floored cell
        if (!inb) begin
          state_nxt = S_END;
        end else begin
          mem_re    = 1'b1;
          cand_nxt  = nonneg;
          cur_x_nxt = pos_x_r[11:8];
          cur_y_nxt = pos_y_r[11:8];
          cur_z_nxt = pos_z_r[11:8];
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        // a new hit flushes the held one; it waits while the output register is full
        if (!(hit && pend_r && !out_free)) begin
          if (hit) begin
            if (pend_r) begin
              out_valid_nxt = 1'b1;
              out_x_nxt = pnd_x_r; out_y_nxt = pnd_y_r; out_z_nxt = pnd_z_r;
              out_hit_nxt = 1'b1; out_last_nxt = 1'b0;
            end
            pend_nxt  = 1'b1;
            pnd_x_nxt = cur_x_r; pnd_y_nxt = cur_y_r; pnd_z_nxt = cur_z_r;
          end
          pos_x_nxt = pos_x_r + stp_x_r;
          pos_y_nxt = pos_y_r + stp_y_r;
          pos_z_nxt = pos_z_r + stp_z_r;
          cnt_nxt   = cnt_inc;
          state_nxt = (cnt_inc > maxit) ? S_END : S_LOOK;
        end
      end
      S_END: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt   = pend_r ? pnd_x_r : 4'd0;
          out_y_nxt   = pend_r ? pnd_y_r : 4'd0;
          out_z_nxt   = pend_r ? pnd_z_r : 4'd0;
          out_hit_nxt = pend_r;
          out_last_nxt = 1'b1;
          pend_nxt    = 1'b0;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      cnt_r       <= '0;
      cand_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      cand_r      <= cand_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_x_r <= pos_x_nxt; pos_y_r <= pos_y_nxt; pos_z_r <= pos_z_nxt;
    stp_x_r <= stp_x_nxt; stp_y_r <= stp_y_nxt; stp_z_r <= stp_z_nxt;
    cur_x_r <= cur_x_nxt; cur_y_r <= cur_y_nxt; cur_z_r <= cur_z_nxt;
    pnd_x_r <= pnd_x_nxt; pnd_y_r <= pnd_y_nxt; pnd_z_r <= pnd_z_nxt;
    out_x_r <= out_x_nxt; out_y_r <= out_y_nxt; out_z_r <= out_z_nxt;
    out_hit_r  <= out_hit_nxt;
    out_last_r <= out_last_nxt;
  end

  vgrm_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_occ (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wa),
    .wdata (mem_wd),
    .re    (mem_re),
    .raddr (mem_ra),
    .rdata (mem_rd)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {4'd0, out_z_r, out_y_r, out_x_r};
  assign out_tlast  = out_last_r;

  // ---------------- checks
  // the march never runs past max extent + 1 steps
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK) |-> (cnt_r <= maxit))
    else $error("march step count beyond limit");

  // no hit is left held once a cast is over
  a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !pend_r)
    else $error("pending hit while idle");

  // nothing is emitted during the clearing pass
  a_clr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !out_valid_r)
    else $error("result during clearing pass");

  // the final word of a cast is loaded only from the end state
  a_last_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r && !$past(out_valid_r && out_last_r)) |->
      ($past(state_r) == S_END))
    else $error("last word not from end state");

endmodule

`default_nettype wire

@@ rtl/vgrm_ram.sv @@
`default_nettype none

module vgrm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire                           clk,
  input  wire                           we,
  input  wire  [$clog2(DEPTH)-1:0]      waddr,
  input  wire  [WIDTH-1:0]              wdata,
  input  wire                           re,
  input  wire  [$clog2(DEPTH)-1:0]      raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];  // holds when re is low
    end
  end

endmodule

`default_nettype wire
